FILE: hw/rtl/trt_pkg.sv
// ----------------------------------------------------------------------------
// Thermistor converter package
// Field widths, register indexes, status codes, constants and the log2 table.
// ----------------------------------------------------------------------------
package trt_pkg;

	localparam int IN_W               = 10;
	localparam int IN_TDATA_W         = 24;
	localparam int OUT_TDATA_W        = 16;
	localparam int OUT_TUSER_W        = 2;
	localparam int ADC_BITS_DEF       = 10;
	localparam int LOG_TABLE_BITS_DEF = 8;

	localparam int RB_W       = 16;
	localparam int R0_W       = 20;
	localparam int BETA_W     = 16;
	localparam int T0_W       = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RES   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_RES  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BETA         = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_TEMP = 2'd3;

	localparam logic [RB_W-1:0]   RB_RESET   = 16'd1000;
	localparam logic [R0_W-1:0]   R0_RESET   = 20'd10000;
	localparam logic [BETA_W-1:0] BETA_RESET = 16'd3950;
	localparam logic [T0_W-1:0]   T0_RESET   = 10'd298;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_BOTTOM_ZERO = 2'd1;
	localparam logic [1:0] ST_NONPOS      = 2'd2;
	localparam logic [1:0] ST_SAT         = 2'd3;

	localparam int FRAC_W = 16;
	localparam int ROM_W  = FRAC_W + 1;
	localparam int MANT_W = 30;
	localparam int LOG_Q16_OFFSET = 16 << FRAC_W;

	localparam int LN2_W = 30;
	localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;

	localparam int SCALE_W = 23;
	localparam logic [SCALE_W-1:0] TEMP_SCALE = 23'd6553600;

	localparam int BT0_W = BETA_W + FRAC_W;
	localparam int D_W   = BT0_W + 1;
	localparam int N_W   = BETA_W + SCALE_W;

	localparam logic [N_W-1:0] CENTI_OFFSET = 39'd27300;
	localparam logic [N_W-1:0] CENTI_SPAN   = 39'd32767;
	localparam logic [OUT_TDATA_W-1:0] TEMP_HI = 16'h7FFF;
	localparam logic [OUT_TDATA_W-1:0] TEMP_LO = 16'h955C;
	localparam logic [OUT_TDATA_W-1:0] TEMP_OFFSET16 = 16'd27300;

	// Fraction of log2 of a Q30 mantissa in [1,2), by repeated squaring.
	function automatic logic [FRAC_W-1:0] frac_log2_q16(input logic [63:0] m0);
		logic [63:0] m;
		logic [FRAC_W-1:0] f;
		m = m0;
		f = '0;
		for (int b = FRAC_W - 1; b >= 0; b--) begin
			m = (m * m) >> MANT_W;
			if (m >= (64'd2 << MANT_W)) begin
				f[b] = 1'b1;
				m = m >> 1;
			end
		end
		return f;
	endfunction

	function automatic logic [ROM_W-1:0] log_rom_entry(input int i, input int tb);
		logic [63:0] m;
		m = (64'd1 << MANT_W) | (64'(i) << (MANT_W - tb));
		if (i >= (1 << tb))
			return ROM_W'(1 << FRAC_W);
		return {1'b0, frac_log2_q16(m)};
	endfunction

endpackage

FILE: hw/rtl/trt_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: brings in one numerator bit, subtracts the
// divisor when it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module trt_div_cell #(
	parameter int NW = 42,
	parameter int DW = 10
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] rem_i,
	input  logic [NW-1:0] num_i,
	input  logic [DW-1:0] div_i,
	output logic [DW-1:0] rem_o,
	output logic [NW-1:0] num_o,
	output logic [DW-1:0] div_o
);
	logic [DW:0] trial;
	logic        fits;
	logic [DW:0] diff;

	always_comb begin
		trial = {rem_i, num_i[NW-1]};
		fits  = trial >= {1'b0, div_i};
		diff  = trial - {1'b0, div_i};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= fits ? diff[DW-1:0] : trial[DW-1:0];
			num_o <= {num_i[NW-2:0], fits};
			div_o <= div_i;
		end
	end
endmodule

FILE: hw/rtl/trt_norm_cell.sv
// ----------------------------------------------------------------------------
// Normalizer cell
// Shifts the word left by a fixed amount when its top bits are all zero and
// records the shift.
// ----------------------------------------------------------------------------
module trt_norm_cell #(
	parameter int W  = 42,
	parameter int SW = 6,
	parameter int SH = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [W-1:0]  x_i,
	input  logic [SW-1:0] s_i,
	output logic [W-1:0]  x_o,
	output logic [SW-1:0] s_o
);
	logic zero_top;

	assign zero_top = (x_i[W-1 -: SH] == '0);

	always_ff @(posedge clk) begin
		if (en) begin
			x_o <= zero_top ? (x_i << SH) : x_i;
			s_o <= zero_top ? (s_i | SW'(SH)) : s_i;
		end
	end
endmodule

FILE: hw/rtl/trt_delay.sv
// ----------------------------------------------------------------------------
// Side-data delay line
// Carries per-item context alongside a unit of fixed latency.
// ----------------------------------------------------------------------------
module trt_delay #(
	parameter int W = 2,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);
	logic [W-1:0] taps_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			taps_q[0] <= d;
			for (int i = 1; i < N; i++)
				taps_q[i] <= taps_q[i-1];
		end
	end

	assign q = taps_q[N-1];
endmodule

FILE: hw/rtl/trt_log2.sv
// ----------------------------------------------------------------------------
// Pipelined log2
// Normalizes through a row of shift cells, then looks up and interpolates the
// fraction. Result is unsigned Q16.
// ----------------------------------------------------------------------------
module trt_log2 #(
	parameter int W = 42,
	parameter int L = 8
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [W-1:0]          x,
	output logic [$clog2(W)+16:0] y
);
	import trt_pkg::*;

	localparam int NL   = $clog2(W);
	localparam int LGW  = NL + ROM_W;
	localparam int RW   = MANT_W - L;
	localparam int ROMN = (1 << L) + 1;
	localparam int PRW  = ROM_W + RW;

	logic [W-1:0]  xs [NL+1];
	logic [NL-1:0] ss [NL+1];

	assign xs[0] = x;
	assign ss[0] = '0;

	for (genvar k = 0; k < NL; k++) begin : g_norm
		trt_norm_cell #(.W(W), .SW(NL), .SH(1 << (NL - 1 - k))) u_cell (
			.clk(clk), .en(en),
			.x_i(xs[k]), .s_i(ss[k]),
			.x_o(xs[k+1]), .s_o(ss[k+1])
		);
	end

	logic [ROM_W-1:0] rom [ROMN];
	for (genvar i = 0; i < ROMN; i++) begin : g_rom
		localparam logic [ROM_W-1:0] V = log_rom_entry(i, L);
		assign rom[i] = V;
	end

	logic [MANT_W:0] mant;
	if (W >= MANT_W + 1) begin : g_trunc
		assign mant = xs[NL][W-1 -: MANT_W+1];
	end else begin : g_pad
		assign mant = {xs[NL], {(MANT_W + 1 - W){1'b0}}};
	end

	logic [L-1:0]     idx;
	logic [RW-1:0]    rest;
	logic [NL-1:0]    expo;
	logic [ROM_W-1:0] lo, hi;

	always_comb begin
		idx  = mant[MANT_W-1 -: L];
		rest = mant[RW-1:0];
		expo = NL'(W - 1) - ss[NL];
		lo   = rom[{1'b0, idx}];
		hi   = rom[(L+1)'({1'b0, idx}) + (L+1)'(1)];
	end

	logic [ROM_W-1:0] lo_s1, step_s1, lo_s2;
	logic [RW-1:0]    rest_s1;
	logic [NL-1:0]    expo_s1, expo_s2;
	logic [PRW-1:0]   prod_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1   <= lo;
			step_s1 <= hi - lo;
			rest_s1 <= rest;
			expo_s1 <= expo;
			lo_s2   <= lo_s1;
			expo_s2 <= expo_s1;
			prod_s2 <= PRW'(step_s1) * PRW'(rest_s1);
			y <= LGW'({expo_s2, {FRAC_W{1'b0}}}) + LGW'(lo_s2) + LGW'(prod_s2 >> RW);
		end
	end
endmodule

FILE: hw/rtl/thermistor_ratio_to_temperature.sv
// ----------------------------------------------------------------------------
// Thermistor ratio to temperature
// Beta-equation conversion of a divider reading pair into 0.01 degC.
//
//   channel   dir  contents
//   s_*       in   tdata: top_reading [9:0], bottom_reading [19:10]
//   m_*       out  tdata: temp_centi_c [15:0]; tuser: status [1:0]
//   cfg_*     in   register index and write data
//
// One item per cycle while the pipeline is not halted; the data runs through
// the chains of restoring divider cells (resistance, B/T0 and final
// quotient) and the log2 normalizer row. The whole pipeline advances
// together and halts only when both entries of the output buffer are full.
// Reset clears valid state and loads the register defaults.
// ----------------------------------------------------------------------------
module thermistor_ratio_to_temperature #(
	parameter int ADC_BITS       = trt_pkg::ADC_BITS_DEF,
	parameter int LOG_TABLE_BITS = trt_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// top_reading [9:0], bottom_reading [19:10]
	input  logic [trt_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// temp_centi_c [15:0]
	output logic [trt_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// status [1:0]
	output logic [trt_pkg::OUT_TUSER_W-1:0]  m_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [trt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [trt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import trt_pkg::*;

	localparam int AW      = (ADC_BITS < IN_W) ? ADC_BITS : IN_W;
	localparam int PW      = AW + RB_W;
	localparam int NW1     = PW + FRAC_W;
	localparam int NL      = $clog2(NW1);
	localparam int LGW     = NL + ROM_W;
	localparam int LOG_LAT = NL + 3;
	localparam int LW      = LGW + 2;
	localparam int MW      = LGW + 1;
	localparam int LAT     = 1 + NW1 + LOG_LAT + 3 + N_W + 1;
	localparam int OW      = OUT_TDATA_W + OUT_TUSER_W;

	// Configuration registers.
	logic [RB_W-1:0]   rb_q;
	logic [R0_W-1:0]   r0_q;
	logic [BETA_W-1:0] beta_q;
	logic [T0_W-1:0]   t0_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rb_q   <= RB_RESET;
			r0_q   <= R0_RESET;
			beta_q <= BETA_RESET;
			t0_q   <= T0_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BOTTOM_RES:   rb_q   <= cfg_data[RB_W-1:0];
				REG_NOMINAL_RES:  r0_q   <= cfg_data[R0_W-1:0];
				REG_BETA:         beta_q <= cfg_data[BETA_W-1:0];
				REG_NOMINAL_TEMP: t0_q   <= cfg_data[T0_W-1:0];
				default: ;
			endcase
		end
	end

	logic [R0_W-1:0] r0_eff;
	logic [T0_W-1:0] t0_eff;
	assign r0_eff = (r0_q == '0) ? R0_W'(1) : r0_q;
	assign t0_eff = (t0_q == '0) ? T0_W'(1) : t0_q;

	// Pipeline control and output buffer.
	logic          en;
	logic [LAT-1:0] vld_q;
	logic [1:0]    cnt_q;
	logic [OW-1:0] ent0_q, ent1_q;
	logic          push, pop;
	logic [OW-1:0] fin;

	assign en       = (cnt_q != 2'd2);
	assign s_tready = en;
	assign push     = en && vld_q[LAT-1];
	assign pop      = (cnt_q != 2'd0) && m_tready;
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = ent0_q[OUT_TDATA_W-1:0];
	assign m_tuser  = ent0_q[OW-1:OUT_TDATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			cnt_q <= '0;
		end else begin
			if (en)
				vld_q <= {vld_q[LAT-2:0], s_tvalid};
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && ((cnt_q - 2'(pop)) == 2'd0))
			ent0_q <= fin;
		else if (pop)
			ent0_q <= ent1_q;
		if (push && ((cnt_q - 2'(pop)) != 2'd0))
			ent1_q <= fin;
	end

	// Stage 1: input checks and resistance numerator.
	logic [AW-1:0] top_in, bot_in, diff_in;
	logic [1:0]    st_in;
	logic [PW-1:0] prod_s1;
	logic [AW-1:0] bot_s1;
	logic [1:0]    st_s1;

	always_comb begin
		top_in  = s_tdata[AW-1:0];
		bot_in  = s_tdata[IN_W + AW - 1 : IN_W];
		diff_in = top_in - bot_in;
		if (bot_in == '0)
			st_in = ST_BOTTOM_ZERO;
		else if (top_in <= bot_in)
			st_in = ST_NONPOS;
		else
			st_in = ST_OK;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PW'(diff_in) * PW'(rb_q);
			bot_s1  <= bot_in;
			st_s1   <= st_in;
		end
	end

	// Resistance in Q16 ohms and B/T0 in Q16, side by side.
	logic [AW-1:0]   rem1 [NW1+1];
	logic [NW1-1:0]  num1 [NW1+1];
	logic [AW-1:0]   div1 [NW1+1];
	logic [T0_W-1:0] rem2 [NW1+1];
	logic [NW1-1:0]  num2 [NW1+1];
	logic [T0_W-1:0] div2 [NW1+1];

	assign rem1[0] = '0;
	assign num1[0] = {prod_s1, {FRAC_W{1'b0}}};
	assign div1[0] = bot_s1;
	assign rem2[0] = '0;
	assign num2[0] = NW1'({beta_q, {FRAC_W{1'b0}}});
	assign div2[0] = t0_eff;

	for (genvar i = 0; i < NW1; i++) begin : g_div1
		trt_div_cell #(.NW(NW1), .DW(AW)) u_res (
			.clk(clk), .en(en),
			.rem_i(rem1[i]), .num_i(num1[i]), .div_i(div1[i]),
			.rem_o(rem1[i+1]), .num_o(num1[i+1]), .div_o(div1[i+1])
		);
		trt_div_cell #(.NW(NW1), .DW(T0_W)) u_bt0 (
			.clk(clk), .en(en),
			.rem_i(rem2[i]), .num_i(num2[i]), .div_i(div2[i]),
			.rem_o(rem2[i+1]), .num_o(num2[i+1]), .div_o(div2[i+1])
		);
	end

	logic [1:0] st_c, st_pre;
	trt_delay #(.W(2), .N(NW1)) u_dly1 (.clk(clk), .en(en), .d(st_s1), .q(st_c));

	assign st_pre = (st_c != ST_OK) ? st_c :
	                (num1[NW1] == '0) ? ST_NONPOS : ST_OK;

	// Logarithms of the resistance and of the nominal resistance.
	logic [LGW-1:0] log_a, log_b;

	trt_log2 #(.W(NW1), .L(LOG_TABLE_BITS)) u_log_r (
		.clk(clk), .en(en), .x(num1[NW1]), .y(log_a)
	);
	trt_log2 #(.W(NW1), .L(LOG_TABLE_BITS)) u_log_r0 (
		.clk(clk), .en(en), .x(NW1'(r0_eff)), .y(log_b)
	);

	logic [BT0_W-1:0] bt0_l;
	logic [1:0]       st_l;
	trt_delay #(.W(2 + BT0_W), .N(LOG_LAT)) u_dly2 (
		.clk(clk), .en(en),
		.d({st_pre, num2[NW1][BT0_W-1:0]}),
		.q({st_l, bt0_l})
	);

	// Stages 2 to 4: ln(R/R0), denominator and numerator of the final quotient.
	logic signed [LW-1:0] l2;
	logic                 neg_s2, neg_s3;
	logic [MW-1:0]        mag_s2, ln_s3;
	logic [BT0_W-1:0]     bt0_s2, bt0_s3;
	logic [1:0]           st_s2, st_s3, st_s4;
	logic [MW+LN2_W-1:0]  ln_prod;
	logic signed [D_W:0]  d_next, d_s4;
	logic [N_W-1:0]       n_s4;

	always_comb begin
		l2 = $signed(LW'(log_a)) - $signed(LW'(LOG_Q16_OFFSET)) - $signed(LW'(log_b));
		ln_prod = (MW+LN2_W)'(mag_s2) * (MW+LN2_W)'(LN2_Q30);
		if (neg_s3)
			d_next = $signed((D_W+1)'(bt0_s3)) - $signed((D_W+1)'(ln_s3));
		else
			d_next = $signed((D_W+1)'(bt0_s3)) + $signed((D_W+1)'(ln_s3));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= l2[LW-1];
			mag_s2 <= l2[LW-1] ? MW'(-l2) : MW'(l2);
			bt0_s2 <= bt0_l;
			st_s2  <= st_l;
			neg_s3 <= neg_s2;
			ln_s3  <= MW'(ln_prod >> LN2_W);
			bt0_s3 <= bt0_s2;
			st_s3  <= st_s2;
			d_s4   <= d_next;
			n_s4   <= N_W'(beta_q) * N_W'(TEMP_SCALE);
			st_s4  <= st_s3;
		end
	end

	// Final quotient B * 6553600 / D.
	logic [D_W-1:0] rem3 [N_W+1];
	logic [N_W-1:0] num3 [N_W+1];
	logic [D_W-1:0] div3 [N_W+1];

	assign rem3[0] = '0;
	assign num3[0] = n_s4;
	assign div3[0] = d_s4[D_W-1:0];

	for (genvar i = 0; i < N_W; i++) begin : g_div3
		trt_div_cell #(.NW(N_W), .DW(D_W)) u_quo (
			.clk(clk), .en(en),
			.rem_i(rem3[i]), .num_i(num3[i]), .div_i(div3[i]),
			.rem_o(rem3[i+1]), .num_o(num3[i+1]), .div_o(div3[i+1])
		);
	end

	logic [1:0] st_f;
	logic       dz_f, dn_f;
	trt_delay #(.W(4), .N(N_W)) u_dly3 (
		.clk(clk), .en(en),
		.d({st_s4, d_s4 == '0, d_s4[D_W]}),
		.q({st_f, dz_f, dn_f})
	);

	// Stage 5: offset to Celsius and saturation.
	logic [N_W-1:0]         q_f, qd;
	logic [OUT_TDATA_W-1:0] temp_n;
	logic [1:0]             status_n;
	logic [OUT_TDATA_W-1:0] temp_s5;
	logic [1:0]             status_s5;

	always_comb begin
		q_f      = num3[N_W];
		qd       = q_f - CENTI_OFFSET;
		temp_n   = '0;
		status_n = ST_OK;
		if (st_f != ST_OK) begin
			status_n = st_f;
		end else if (dz_f) begin
			temp_n   = TEMP_HI;
			status_n = ST_SAT;
		end else if (dn_f) begin
			temp_n   = TEMP_LO;
			status_n = ST_SAT;
		end else if (q_f >= CENTI_OFFSET) begin
			if (qd > CENTI_SPAN) begin
				temp_n   = TEMP_HI;
				status_n = ST_SAT;
			end else begin
				temp_n = qd[OUT_TDATA_W-1:0];
			end
		end else begin
			// Below the offset the quotient rounds up, toward zero.
			temp_n = q_f[OUT_TDATA_W-1:0] - TEMP_OFFSET16
			         + OUT_TDATA_W'(rem3[N_W] != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s5   <= temp_n;
			status_s5 <= status_n;
		end
	end

	assign fin = {status_s5, temp_s5};
endmodule
